### design/rpn_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpn_pkg;

	localparam int DATA_W = 32;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_DIV0  = 3'd1,
		STAT_UNDER = 3'd2,
		STAT_OVER  = 3'd3,
		STAT_EMPTY = 3'd4
	} status_t;

	// Per-cell load select
	typedef enum logic [1:0] {
		CELL_HOLD    = 2'd0,
		CELL_FROM_UP = 2'd1,
		CELL_FROM_DN = 2'd2
	} cell_cmd_t;

	// Whole-stack operation
	typedef enum logic [1:0] {
		STK_HOLD    = 2'd0,
		STK_PUSH    = 2'd1,
		STK_SET     = 2'd2,
		STK_POP_SET = 2'd3
	} stk_op_t;

endpackage

`default_nettype wire

### design/rpn_cell.sv
// One stack cell: a single entry of the shift-register stack.
// Depends on rpn_pkg for the cell command type.
`default_nettype none

module rpn_cell
	import rpn_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] up_val,
	input  wire logic [DATA_W-1:0] dn_val,
	output logic      [DATA_W-1:0] val
);

	logic [DATA_W-1:0] data_q;

	// take the neighbour nearer the top on a push, the deeper one on a pop
	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_FROM_UP: data_q <= up_val;
			CELL_FROM_DN: data_q <= dn_val;
			default:      data_q <= data_q;
		endcase
	end

	assign val = data_q;

endmodule

`default_nettype wire

### design/rpn_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for the data width.
`default_nettype none

module rpn_div
	import rpn_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic      [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] quotient_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W-1:0] a_mag;
	logic [DATA_W-1:0] b_mag;

	assign a_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign b_mag = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == CNT_W'(DATA_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			dvs_q <= b_mag;
			rem_q <= '0;
			quo_q <= a_mag;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
		// apply the sign as a separate registered step after the last quotient bit
		if (fin_q) begin
			quotient_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule

`default_nettype wire

### design/postfix_expression_evaluator_top.sv
// Postfix expression evaluator: top level with the stack cell row and control.
// Depends on rpn_pkg, rpn_cell and rpn_div.
//
// Usage:
//   Input requests arrive on the s_ channel, one ASCII character each in
//   s_tdata[7:0]; s_tlast marks the final character of an expression.
//   Digits build a number, any other character ends and pushes it, and
//   + - * / pop two values and push the result (32-bit wrapping signed).
//   On the last character one result request leaves on the m_ channel:
//   m_tdata[31:0] is the top of stack, m_tdata[34:32] the status
//   (ok, divide by zero, underflow, overflow, empty stack).
//   Characters are taken back to back unless a result is stalled; '/'
//   holds the input while the iterative divider produces one quotient bit
//   per cycle and then applies the sign, and so sets the worst-case rate.
//   Latency: the result is registered and appears in the cycle after the
//   last character is taken (after the divider if that character is '/').
//   The stack is a row of cells that shift toward or away from the top.
//   Reset clears the count, the number being built and the error; the
//   cells themselves are not cleared. After every result the same state
//   returns to its reset values. When the receiver stalls, the result is
//   held and no character is taken until that result has left.
`default_nettype none

module postfix_expression_evaluator_top
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // is_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata    // [31:0] result_value, [34:32] status, rest zero
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DIV  = 2'b10
	} fsm_t;

	fsm_t              state_q, state_d;
	logic [CW-1:0]     count_q, count_d, count_n;
	logic [DATA_W-1:0] acc_q, acc_d, acc_digit;
	logic              pend_q, pend_d;
	status_t           err_q, err_d, err_n;
	logic              div_pop_q, div_pop_d;
	logic              div_last_q, div_last_d;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] res_value_q;
	status_t           res_status_q;

	logic              accept;
	logic              is_digit;
	logic              is_op;
	logic [7:0]        ch;
	logic [DATA_W-1:0] opa, opb, alu_r, prod;
	logic              have2;
	logic              div_start, div_done;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W-1:0] top_n;
	logic              fin;
	logic              res_load;
	logic [DATA_W-1:0] res_value;
	status_t           res_status;
	stk_op_t           stk_op;
	logic [DATA_W-1:0] stk_din;
	logic [DATA_W-1:0] cell_val [STACK_DEPTH];
	cell_cmd_t         cell_cmd [STACK_DEPTH];

	assign ch       = s_tdata;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_op    = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);

	// accumulator times ten plus the new digit, as shifts and adds
	assign acc_digit = (acc_q << 3) + (acc_q << 1) + DATA_W'(ch - CH_ZERO);

	// With a pending number, it is the right operand and the top cell the left one.
	assign opb   = pend_q ? acc_q : cell_val[0];
	assign opa   = pend_q ? cell_val[0] : cell_val[1];
	assign have2 = pend_q ? (count_q != '0) : (count_q >= CW'(2));
	assign prod  = opa * opb;

	always_comb begin
		priority if (ch == CH_PLUS) begin
			alu_r = opa + opb;
		end else if (ch == CH_MINUS) begin
			alu_r = opa - opb;
		end else begin
			alu_r = prod;
		end
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (opa),
		.divisor  (opb),
		.done     (div_done),
		.quotient (div_q)
	);

	// Control: decide the stack operation, next state and any result.
	always_comb begin
		state_d    = state_q;
		count_n    = count_q;
		acc_d      = acc_q;
		pend_d     = pend_q;
		err_n      = err_q;
		div_pop_d  = div_pop_q;
		div_last_d = div_last_q;
		stk_op     = STK_HOLD;
		stk_din    = alu_r;
		div_start  = 1'b0;
		top_n      = cell_val[0];
		fin        = 1'b0;

		unique case (state_q)
			S_DIV: begin
				if (div_done) begin
					stk_din = div_q;
					top_n   = div_q;
					state_d = S_IDLE;
					if (div_pop_q) begin
						stk_op  = STK_POP_SET;
						count_n = count_q - 1'b1;
					end else begin
						stk_op = STK_SET;
					end
					fin = div_last_q;
				end
			end
			S_IDLE: begin
				if (accept) begin
					fin = s_tlast;
					if (err_q != STAT_OK) begin
						// sticky error: drop the character
					end else if (is_digit) begin
						if (s_tlast) begin
							if (count_q == CW'(STACK_DEPTH)) begin
								err_n = STAT_OVER;
							end else begin
								stk_op  = STK_PUSH;
								stk_din = acc_digit;
								count_n = count_q + 1'b1;
								top_n   = acc_digit;
							end
						end else begin
							acc_d  = acc_digit;
							pend_d = 1'b1;
						end
					end else begin
						acc_d  = '0;
						pend_d = 1'b0;
						if (pend_q && (count_q == CW'(STACK_DEPTH))) begin
							err_n = STAT_OVER;
						end else if (is_op) begin
							if (!have2) begin
								err_n = STAT_UNDER;
							end else if ((ch == CH_SLASH) && (opb == '0)) begin
								err_n = STAT_DIV0;
							end else if (ch == CH_SLASH) begin
								// hold the input until the quotient is back
								div_start  = 1'b1;
								div_pop_d  = !pend_q;
								div_last_d = s_tlast;
								state_d    = S_DIV;
								fin        = 1'b0;
							end else begin
								top_n = alu_r;
								if (pend_q) begin
									stk_op = STK_SET;
								end else begin
									stk_op  = STK_POP_SET;
									count_n = count_q - 1'b1;
								end
							end
						end else if (pend_q) begin
							stk_op  = STK_PUSH;
							stk_din = acc_q;
							count_n = count_q + 1'b1;
							top_n   = acc_q;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// form the result and, when one is produced, return to the reset state
		res_load   = fin;
		res_value  = '0;
		res_status = STAT_OK;
		if (err_n != STAT_OK) begin
			res_status = err_n;
		end else if (count_n == '0) begin
			res_status = STAT_EMPTY;
		end else begin
			res_value = top_n;
		end
		if (fin) begin
			count_d = '0;
			acc_d   = '0;
			pend_d  = 1'b0;
			err_d   = STAT_OK;
		end else begin
			count_d = count_n;
			err_d   = err_n;
		end
	end

	// Stack cell row: cell 0 is the top of stack.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] up_val;
		logic [DATA_W-1:0] dn_val;

		if (i == 0) begin : g_top
			assign up_val = stk_din;
			always_comb begin
				unique case (stk_op)
					STK_PUSH, STK_SET, STK_POP_SET: cell_cmd[i] = CELL_FROM_UP;
					default:                        cell_cmd[i] = CELL_HOLD;
				endcase
			end
		end else begin : g_rest
			assign up_val = cell_val[i-1];
			always_comb begin
				unique case (stk_op)
					STK_PUSH:    cell_cmd[i] = CELL_FROM_UP;
					STK_POP_SET: cell_cmd[i] = CELL_FROM_DN;
					default:     cell_cmd[i] = CELL_HOLD;
				endcase
			end
		end

		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign dn_val = '0;
		end else begin : g_inner
			assign dn_val = cell_val[i+1];
		end

		rpn_cell u_cell (
			.clk    (clk),
			.cmd    (cell_cmd[i]),
			.up_val (up_val),
			.dn_val (dn_val),
			.val    (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			acc_q      <= '0;
			pend_q     <= 1'b0;
			err_q      <= STAT_OK;
			div_pop_q  <= 1'b0;
			div_last_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			acc_q      <= acc_d;
			pend_q     <= pend_d;
			err_q      <= err_d;
			div_pop_q  <= div_pop_d;
			div_last_q <= div_last_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_value_q  <= res_value;
			res_status_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, res_status_q, res_value_q};

	// Assertions
	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !s_tready)
		else $error("input taken while the divider is busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (count_q == '0) && !pend_q && (err_q == STAT_OK))
		else $error("state not cleared after a result");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("quotient returned outside a division");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !res_load)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire
